FILE: hw/rtl/ret_pkg.sv
// shared types, constants and codes of the endpoint table
`default_nettype none
package ret_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned REF_W = 32;

  typedef enum logic [0:0] {
    CMD_REF   = 1'b0,
    CMD_UNREF = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic        is_v4;
    logic [31:0] table_index;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } key_t;

  typedef struct packed {
    key_t             key;
    logic [REF_W-1:0] count;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // outcome of one slot probe
  typedef struct packed {
    logic hit;
    logic free;
  } cmp_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ret_ram.sv
// generic single write port ram with registered read
`default_nettype none
module ret_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ret_key_cmp.sv
// shared key comparator, probes one stored slot per cycle
`default_nettype none
module ret_key_cmp
  import ret_pkg::*;
(
  input  wire logic     probe_vld_i,
  input  wire logic     slot_valid_i,
  input  wire key_t     stored_i,
  input  wire key_t     probe_i,
  output cmp_res_t      res_o
);

  always_comb begin
    res_o.hit  = probe_vld_i && slot_valid_i && (stored_i == probe_i);
    res_o.free = probe_vld_i && !slot_valid_i;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/refcounted_endpoint_table_core.sv
// top level: sequencer, valid bits and update logic of the endpoint table
// sequence: start is latched in idle, then the scan reads one slot of the entry ram per
//   cycle and compares the registered read against the latched key; a hit in slot k ends
//   the scan there, a miss runs to the last slot; the update step follows and done_o is
//   registered from it; a new start is taken in the done_o cycle, while busy it is ignored
// reset: rst_ni clears all entry valid bits at once, no clearing pass; the receiver
//   cannot stall, done_o flags each result for exactly one cycle
`default_nettype none
module refcounted_endpoint_table_core
  import ret_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command_i,
  input  wire logic        is_v4_i,
  input  wire logic [31:0] table_index_i,
  input  wire logic [63:0] addr_hi_i,
  input  wire logic [63:0] addr_lo_i,
  output logic             done_o,
  output logic [31:0]      ref_count_o,
  output logic [1:0]       status_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  key_t                 key_q, key_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic [REF_W-1:0]     hit_cnt_q, hit_cnt_d;
  logic                 free_found_q, free_found_d;
  logic [IDX_W-1:0]     free_idx_q, free_idx_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic                 done_q, done_d;
  logic [REF_W-1:0]     ref_count_q, ref_count_d;
  status_e              status_q, status_d;

  logic                 issue_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  entry_t               ram_rdata;
  cmp_res_t             cmp_res;
  logic                 start_xfer;
  logic                 last_probe;
  key_t                 probe_key;

  assign start_xfer = start && !busy;
  assign busy       = (state_q != ST_IDLE);

  // ipv4 keys ignore addr_hi and the upper half of addr_lo
  always_comb begin
    probe_key.is_v4       = is_v4_i;
    probe_key.table_index = table_index_i;
    probe_key.addr_hi     = is_v4_i ? 64'd0 : addr_hi_i;
    probe_key.addr_lo     = is_v4_i ? {32'd0, addr_lo_i[31:0]} : addr_lo_i;
  end

  // read side of the scan: one slot address issued per cycle
  assign issue_en   = (state_q == ST_SCAN) && (cnt_q < CNT_W'(TABLE_ENTRIES));
  assign rd_addr    = cnt_q[IDX_W-1:0];
  assign last_probe = cmp_vld_q && (cmp_idx_q == IDX_W'(TABLE_ENTRIES - 1));

  ret_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // compare slot read in the previous cycle against the latched key
  ret_key_cmp u_key_cmp (
    .probe_vld_i  (cmp_vld_q),
    .slot_valid_i (valid_q[cmp_idx_q]),
    .stored_i     (ram_rdata.key),
    .probe_i      (key_q),
    .res_o        (cmp_res)
  );

  // update step: at most one write into the entry ram, chosen by hit and command
  always_comb begin
    ram_we            = 1'b0;
    ram_waddr         = hit_q ? hit_idx_q : free_idx_q;
    ram_wdata.key     = key_q;
    ram_wdata.count   = REF_W'(1);
    valid_d           = valid_q;
    ref_count_d       = ref_count_q;
    status_d          = status_q;
    done_d            = 1'b0;
    if (state_q == ST_UPD) begin
      done_d = 1'b1;
      unique case (cmd_q)
        CMD_REF: begin
          if (hit_q) begin
            // saturate at all ones
            ram_wdata.count = (&hit_cnt_q) ? hit_cnt_q : hit_cnt_q + REF_W'(1);
            ram_we          = 1'b1;
            ref_count_d     = ram_wdata.count;
            status_d        = STATUS_OK;
          end else if (free_found_q) begin
            ram_wdata.count       = REF_W'(1);
            ram_we                = 1'b1;
            valid_d[free_idx_q]   = 1'b1;
            ref_count_d           = REF_W'(1);
            status_d              = STATUS_OK;
          end else begin
            ref_count_d = '0;
            status_d    = STATUS_FULL;
          end
        end
        CMD_UNREF: begin
          if (hit_q) begin
            ram_wdata.count = hit_cnt_q - REF_W'(1);
            ram_we          = 1'b1;
            ref_count_d     = ram_wdata.count;
            status_d        = STATUS_OK;
            // last reference gone, slot becomes free
            if (ram_wdata.count == '0) begin
              valid_d[hit_idx_q] = 1'b0;
            end
          end else begin
            ref_count_d = '0;
            status_d    = STATUS_ABSENT;
          end
        end
        default: begin
          ref_count_d = '0;
          status_d    = STATUS_ABSENT;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    cnt_d        = cnt_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_cnt_d    = hit_cnt_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    cmp_idx_d    = rd_addr;
    unique case (state_q)
      ST_IDLE: begin
        if (start_xfer) begin
          state_d      = ST_SCAN;
          cmd_d        = cmd_e'(command_i);
          key_d        = probe_key;
          cnt_d        = '0;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue_en) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        // lowest free slot wins
        if (cmp_res.free && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = cmp_idx_q;
        end
        if (cmp_res.hit) begin
          state_d   = ST_UPD;
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          hit_cnt_d = ram_rdata.count;
        end else if (last_probe) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    cmp_vld_d = issue_en && (state_d == ST_SCAN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmp_vld_q    <= 1'b0;
      valid_q      <= '0;
      done_q       <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      cmp_vld_q    <= cmp_vld_d;
      valid_q      <= valid_d;
      done_q       <= done_d;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      cnt_q        <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    cmp_idx_q   <= cmp_idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_cnt_q   <= hit_cnt_d;
    free_idx_q  <= free_idx_d;
    ref_count_q <= ref_count_d;
    status_q    <= status_d;
  end

  assign done_o      = done_q;
  assign ref_count_o = ref_count_q;
  assign status_o    = status_q;

  // a result only follows an update step
  a_done_after_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_UPD))
    else $error("result without update step");

  // table full is reported only when every slot holds a key
  a_full_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STATUS_FULL)) |-> (&valid_q))
    else $error("full status with a free slot");

  // a zero count with ok status only comes from dropping the last reference
  a_zero_only_unref : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STATUS_OK) && (ref_count_o == '0)) |-> (cmd_q == CMD_UNREF))
    else $error("zero count on add reference");

  // an update step never overlaps a pending slot compare
  a_no_issue_in_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> !cmp_vld_q)
    else $error("scan still running in update step");

endmodule
`default_nettype wire
